/* rtl/core/isa_pkg.sv */
// Shared types and constants for the indexed shift array.
package isa_pkg;

  // Fixed field widths of the transaction payloads
  localparam int IDX_W     = 5;
  localparam int VAL_W     = 32;
  localparam int CNT_FLD_W = 5;

  // Defaults for the top-level parameters
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    FN_GET    = 2'd0,
    FN_SET    = 2'd1,
    FN_INSERT = 2'd2,
    FN_REMOVE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Per-cycle command broadcast along the row of cells
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e             mode;
    logic [IDX_W-1:0] pos;
  } cell_cmd_t;

  typedef struct packed {
    func_e            func;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0]     data;
    status_e              status;
    logic [CNT_FLD_W-1:0] count;
    logic [CNT_FLD_W-1:0] capacity;
  } out_t;

endpackage

/* rtl/core/isa_cell.sv */
// One storage cell of the array: hold, load, or take a neighbor's value.
module isa_cell import isa_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int CELL_IDX   = 0
) (
  input  logic                  clk_i,
  input  cell_cmd_t             cmd_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] q_o
);

  logic [DATA_WIDTH-1:0] q_q, q_d;
  logic                  at_pos, past_pos;

  assign at_pos   = int'(cmd_i.pos) == CELL_IDX;
  assign past_pos = CELL_IDX > int'(cmd_i.pos);

  // Select the next content from the broadcast command
  always_comb begin
    q_d = q_q;
    case (cmd_i.mode)
      CMD_WRITE: begin
        if (at_pos) q_d = value_i;
      end
      CMD_INSERT: begin
        if (at_pos) q_d = value_i;
        else if (past_pos) q_d = left_i;
      end
      CMD_REMOVE: begin
        if (at_pos || past_pos) q_d = right_i;
      end
      default: q_d = q_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign q_o = q_q;

endmodule

/* rtl/core/isa_ctrl.sv */
// Operation decode, range checks, and entry count and capacity bookkeeping.
module isa_ctrl import isa_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             acc_i,
  input  func_e            func_i,
  input  logic [IDX_W-1:0] index_i,
  output cell_cmd_t        cmd_o,
  output status_e          status_o,
  output logic             rd_en_o,
  output logic [CNT_W-1:0] count_o,
  output logic [CNT_W-1:0] cap_o
);

  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] cap_q, cap_d;
  logic [CMP_W-1:0] idx_c, cnt_c;
  logic             in_range, at_end, is_full;
  logic [CNT_W:0]   cap_dbl;
  logic [CNT_W-1:0] cap_grow, cnt_dec;
  status_e          status;
  cmd_e             mode;
  logic             rd_en;

  assign idx_c    = CMP_W'(index_i);
  assign cnt_c    = CMP_W'(count_q);
  assign in_range = idx_c < cnt_c;
  assign at_end   = idx_c == cnt_c;
  assign is_full  = count_q == CNT_W'(DEPTH);

  // Double capacity, saturating at the physical depth
  assign cap_dbl  = {cap_q, 1'b0};
  assign cap_grow = (cap_dbl > (CNT_W + 1)'(DEPTH)) ? CNT_W'(DEPTH) : cap_dbl[CNT_W-1:0];
  assign cnt_dec  = count_q - CNT_W'(1);

  // Decode the operation into a status, a cell command and a read flag
  always_comb begin
    status = ST_OK;
    mode   = CMD_HOLD;
    rd_en  = 1'b0;
    case (func_i)
      FN_GET: begin
        if (in_range) rd_en = 1'b1;
        else status = ST_RANGE;
      end
      FN_SET: begin
        if (in_range) begin
          rd_en = 1'b1;
          mode  = CMD_WRITE;
        end else if (at_end) begin
          if (is_full) status = ST_FULL;
          else mode = CMD_INSERT;
        end else begin
          status = ST_RANGE;
        end
      end
      FN_INSERT: begin
        if (in_range || at_end) begin
          if (is_full) status = ST_FULL;
          else mode = CMD_INSERT;
        end else begin
          status = ST_RANGE;
        end
      end
      FN_REMOVE: begin
        if (in_range) begin
          rd_en = 1'b1;
          mode  = CMD_REMOVE;
        end else begin
          status = ST_RANGE;
        end
      end
      default: status = ST_RANGE;
    endcase
  end

  // Advance count and capacity on a successful insert or remove
  always_comb begin
    count_d = count_q;
    cap_d   = cap_q;
    case (mode)
      CMD_INSERT: begin
        count_d = count_q + CNT_W'(1);
        if (count_q == cap_q) cap_d = cap_grow;
      end
      CMD_REMOVE: begin
        count_d = cnt_dec;
        if (cnt_dec == '0) cap_d = CNT_W'(1);
        else if (cnt_dec < (cap_q >> 2)) cap_d = cap_q >> 1;
      end
      default: begin
        count_d = count_q;
        cap_d   = cap_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= CNT_W'(1);
    end else if (acc_i) begin
      count_q <= count_d;
      cap_q   <= cap_d;
    end
  end

  assign cmd_o.mode = acc_i ? mode : CMD_HOLD;
  assign cmd_o.pos  = index_i;
  assign status_o   = status;
  assign rd_en_o    = rd_en;
  assign count_o    = count_d;
  assign cap_o      = cap_d;

`ifndef NO_ASSERTIONS
  a_count_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_q) else $error("entry count exceeds capacity");

  a_cap_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_q != '0 && cap_q <= CNT_W'(DEPTH)) else $error("capacity out of bounds");

  a_err_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && status != ST_OK |=> $stable(count_q) && $stable(cap_q))
    else $error("error transaction changed state");

  a_full_only_at_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status == ST_FULL |-> is_full) else $error("full status below depth");
`endif

endmodule

/* rtl/core/indexed_shift_array_unit.sv */
// Result: registered, and presented the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle while results are taken; every cell shifts from
//   its neighbor in the same cycle, so insert and remove take no longer than get and set.
// Reset: asynchronous, active low; clears entry count to zero and capacity to one.
//   Cell contents are not reset and are only read below the entry count.
module indexed_shift_array_unit import isa_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WIDE_W = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;

  logic                  acc;
  cell_cmd_t             cmd;
  status_e               status;
  logic                  rd_en;
  logic [CNT_W-1:0]      count_nx, cap_nx;
  logic [WIDE_W-1:0]     val_wide, rd_wide;
  logic [DATA_WIDTH-1:0] val_cell, rd_data;
  logic [DATA_WIDTH-1:0] cell_q [DEPTH];
  logic                  out_valid_q;
  out_t                  out_q, out_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign acc        = in_valid_i && in_ready_o;

  isa_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (acc),
    .func_i   (in_data_i.func),
    .index_i  (in_data_i.index),
    .cmd_o    (cmd),
    .status_o (status),
    .rd_en_o  (rd_en),
    .count_o  (count_nx),
    .cap_o    (cap_nx)
  );

  // Fit the input value to the cell width
  assign val_wide = WIDE_W'(in_data_i.value);
  assign val_cell = val_wide[DATA_WIDTH-1:0];

  // Row of cells; the ends feed back their own content
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = cell_q[g];
    end else begin : g_mid_l
      assign left = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right = cell_q[g];
    end else begin : g_mid_r
      assign right = cell_q[g+1];
    end
    isa_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CELL_IDX   (g)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .value_i (val_cell),
      .left_i  (left),
      .right_i (right),
      .q_o     (cell_q[g])
    );
  end

  // Select the addressed cell
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (int'(in_data_i.index) == i) rd_data = cell_q[i];
    end
  end

  assign rd_wide = WIDE_W'(rd_data);

  // Build the result transaction
  always_comb begin
    out_d.data     = rd_en ? rd_wide[VAL_W-1:0] : '0;
    out_d.status   = status;
    out_d.count    = CNT_FLD_W'(count_nx);
    out_d.capacity = CNT_FLD_W'(cap_nx);
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_acc_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> out_valid_o) else $error("accepted transaction produced no result");

  a_no_cmd_without_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc |-> cmd.mode == CMD_HOLD) else $error("cells changed without a transaction");

  a_err_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && status != ST_OK |=> out_data_o.data == '0)
    else $error("error result carries data");
`endif

endmodule
